>>> sv/sav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source address validation package
// Shared types, operation codes and constants of the validation pipeline.
// ----------------------------------------------------------------------------
package sav_pkg;

  // Operation carried with each input transaction.
  typedef enum logic [1:0] {
    FUNC_CHECK    = 2'd0,
    FUNC_WR_BIND  = 2'd1,
    FUNC_WR_RANGE = 2'd2,
    FUNC_RD_CNT   = 2'd3
  } func_e;

  // Validation modes.
  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_STRICT   = 2'd1,
    MODE_LOOSE    = 2'd2,
    MODE_LOG_ONLY = 2'd3
  } mode_e;

  // Header presence codes; the remaining codes count as a full header.
  localparam logic [1:0] HDR_SHORT = 2'd0;
  localparam logic [1:0] HDR_ETH   = 2'd1;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_ENABLE   = 8'd1;
  localparam int unsigned CFG_DATA_W = 8;

  // Statistics counters.
  localparam int unsigned NUM_CNT   = 5;
  localparam int unsigned CNT_IDX_W = 3;
  localparam int unsigned CNT_ALLOWED = 0;
  localparam int unsigned CNT_DROPPED = 1;
  localparam int unsigned CNT_LOGGED  = 2;
  localparam int unsigned CNT_V4_VIOL = 3;
  localparam int unsigned CNT_V6_VIOL = 4;

  // Bit positions within entry_flags.
  localparam int unsigned FLAG_VALID = 0;
  localparam int unsigned FLAG_V4    = 1;
  localparam int unsigned FLAG_V6    = 2;

  // One input item.
  typedef struct packed {
    func_e        func;
    logic [7:0]   slot;
    logic [47:0]  src_mac;
    logic [15:0]  ethertype;
    logic [1:0]   header_presence;
    logic [31:0]  v4_addr;
    logic [63:0]  ipv6_high;
    logic [63:0]  ipv6_low;
    logic [2:0]   entry_flags;
    logic [1:0]   entry_mode;
    logic [5:0]   prefix_length;
  } item_t;

  // Binding payload kept in the binding memory.
  typedef struct packed {
    mode_e        mode;
    logic         v6_ok;
    logic         v4_ok;
    logic [31:0]  ipv4;
    logic [63:0]  ipv6_high;
    logic [63:0]  ipv6_low;
  } bind_data_t;

  // Binding lookup outcome handed to the verdict stage.
  typedef struct packed {
    logic         hit;
    bind_data_t   data;
  } bind_look_t;

  // One result item.
  typedef struct packed {
    logic         verdict;
    logic         log_valid;
    logic         log_is_ipv6;
    logic [47:0]  log_mac;
    logic [31:0]  log_spoofed_ipv4;
    logic [31:0]  log_allowed_ipv4;
    logic [63:0]  counter_value;
  } result_t;

endpackage

>>> sv/source_address_validation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source address validation
// Checks packet source addresses against a MAC binding table and an IPv4
// prefix table, and also writes table slots and reads statistics counters.
// ----------------------------------------------------------------------------
// An accepted input transaction moves from the input register (table
// compare) through the registered payload read to the verdict in the
// output register. Throughput: one transaction per cycle unless
// m_axis_tready stalls the output; the binding compare and the registered
// payload memory read set the single-cycle stage.
// Reset clears the configuration, all valid bits and the statistics counters
// at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module source_address_validation #(
  parameter int unsigned BINDINGS = 64,
  parameter int unsigned RANGES   = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: slot, src_mac, ethertype, header_presence, v4_addr,
  // ipv6_high, ipv6_low, entry_flags, entry_mode, prefix_length, zero pad.
  input  logic [247:0]                  s_axis_tdata,
  // tuser: func.
  input  logic [1:0]                    s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0: verdict, log_is_ipv6, log_mac, log_spoofed_ipv4,
  // log_allowed_ipv4, counter_value, zero pad.
  output logic [183:0]                  m_axis_tdata,
  // tuser: log_valid.
  output logic [0:0]                    m_axis_tuser,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sav_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sav_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sav_pkg::*;

  item_t      in_item;
  item_t      a_q;
  item_t      b_q;
  logic       a_valid_q;
  logic       b_valid_q;
  logic       c_valid_q;
  result_t    c_q;
  result_t    b_res;
  logic       a_adv;
  logic       b_adv;
  logic       in_acc;
  mode_e      default_mode_q;
  logic       log_enable_q;
  bind_look_t bind_look;
  bind_data_t bind_wr;
  logic       range_hit;

  // Unpack the input transaction.
  assign in_item.func            = func_e'(s_axis_tuser);
  assign in_item.slot            = s_axis_tdata[7:0];
  assign in_item.src_mac         = s_axis_tdata[55:8];
  assign in_item.ethertype       = s_axis_tdata[71:56];
  assign in_item.header_presence = s_axis_tdata[73:72];
  assign in_item.v4_addr         = s_axis_tdata[105:74];
  assign in_item.ipv6_high       = s_axis_tdata[169:106];
  assign in_item.ipv6_low        = s_axis_tdata[233:170];
  assign in_item.entry_flags     = s_axis_tdata[236:234];
  assign in_item.entry_mode      = s_axis_tdata[238:237];
  assign in_item.prefix_length   = s_axis_tdata[244:239];

  // Pipeline flow control.
  assign b_adv         = b_valid_q && (!c_valid_q || m_axis_tready);
  assign a_adv         = a_valid_q && (!b_valid_q || b_adv);
  assign s_axis_tready = !a_valid_q || a_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) a_valid_q <= s_axis_tvalid;
      if (!b_valid_q || b_adv) b_valid_q <= a_adv;
      if (!c_valid_q || m_axis_tready) c_valid_q <= b_adv;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    if (in_acc) a_q <= in_item;
    if (a_adv) b_q <= a_q;
    if (b_adv) c_q <= b_res;
  end

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_mode_q <= MODE_DISABLED;
      log_enable_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEFAULT_MODE: default_mode_q <= mode_e'(cfg_data_i[1:0]);
        CFG_LOG_ENABLE:   log_enable_q   <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // Tables are written and looked up as the item leaves the first stage.
  assign bind_wr.mode      = mode_e'(a_q.entry_mode);
  assign bind_wr.v6_ok     = a_q.entry_flags[FLAG_V6];
  assign bind_wr.v4_ok     = a_q.entry_flags[FLAG_V4];
  assign bind_wr.ipv4      = a_q.v4_addr;
  assign bind_wr.ipv6_high = a_q.ipv6_high;
  assign bind_wr.ipv6_low  = a_q.ipv6_low;

  sav_bind_table #(
    .BINDINGS (BINDINGS)
  ) u_bind (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (a_adv && (a_q.func == FUNC_WR_BIND)),
    .wr_slot_i  (a_q.slot),
    .wr_valid_i (a_q.entry_flags[FLAG_VALID]),
    .wr_mac_i   (a_q.src_mac),
    .wr_data_i  (bind_wr),
    .look_en_i  (a_adv),
    .look_mac_i (a_q.src_mac),
    .look_o     (bind_look)
  );

  sav_range_table #(
    .RANGES (RANGES)
  ) u_range (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (a_adv && (a_q.func == FUNC_WR_RANGE)),
    .wr_slot_i   (a_q.slot),
    .wr_valid_i  (a_q.entry_flags[FLAG_VALID]),
    .wr_base_i   (a_q.v4_addr),
    .wr_length_i (a_q.prefix_length),
    .look_en_i   (a_adv),
    .look_ip_i   (a_q.v4_addr),
    .hit_o       (range_hit)
  );

  sav_verdict u_verdict (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (b_adv),
    .item_i         (b_q),
    .bind_i         (bind_look),
    .range_hit_i    (range_hit),
    .default_mode_i (default_mode_q),
    .log_enable_i   (log_enable_q),
    .result_o       (b_res)
  );

  // Pack the result transaction.
  assign m_axis_tvalid   = c_valid_q;
  assign m_axis_tuser[0] = c_q.log_valid;
  assign m_axis_tdata    = {6'd0, c_q.counter_value, c_q.log_allowed_ipv4,
                            c_q.log_spoofed_ipv4, c_q.log_mac, c_q.log_is_ipv6,
                            c_q.verdict};

  // An item leaving a stage always lands in the next one.
  a_adv_fills_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv |=> b_valid_q) else $error("first stage item lost");

  b_adv_fills_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> c_valid_q) else $error("verdict stage item lost");

  // A violation record never carries a counter value.
  log_no_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_valid_q && c_q.log_valid) |-> (c_q.counter_value == 64'd0))
    else $error("log record with counter value");

  // An empty first stage always takes a new transaction.
  empty_is_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |-> s_axis_tready) else $error("input stalled while empty");

endmodule

>>> sv/sav_bind_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binding table
// MAC tags with one comparator per slot, lowest-slot priority select and a
// payload memory read at the selected slot into a registered output.
// ----------------------------------------------------------------------------
module sav_bind_table #(
  parameter int unsigned BINDINGS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [7:0]          wr_slot_i,
  input  logic                wr_valid_i,
  input  logic [47:0]         wr_mac_i,
  input  sav_pkg::bind_data_t wr_data_i,
  input  logic                look_en_i,
  input  logic [47:0]         look_mac_i,
  output sav_pkg::bind_look_t look_o
);
  import sav_pkg::*;

  localparam int unsigned IDX_W = (BINDINGS > 1) ? $clog2(BINDINGS) : 1;

  logic               valid_q [BINDINGS];
  logic [47:0]        mac_q   [BINDINGS];
  bind_data_t         mem_q   [BINDINGS];
  logic [BINDINGS-1:0] match;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   hit_idx;
  logic               wr_ok;
  logic               hit_q;
  bind_data_t         rd_q;

  assign wr_idx = IDX_W'(wr_slot_i);
  assign wr_ok  = wr_en_i && (32'(wr_slot_i) < BINDINGS);

  // Valid bits clear at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BINDINGS; i++) valid_q[i] <= 1'b0;
    end else if (wr_ok) begin
      valid_q[wr_idx] <= wr_valid_i;
    end
  end

  // MAC tags are written together with the valid bit.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mac_q[wr_idx] <= wr_mac_i;
    end
  end

  // Tag compare on every slot in parallel.
  always_comb begin
    for (int i = 0; i < BINDINGS; i++) match[i] = valid_q[i] && (mac_q[i] == look_mac_i);
  end

  // The lowest matching slot wins.
  always_comb begin
    hit_idx = '0;
    for (int i = BINDINGS - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDX_W'(i);
    end
  end

  // Payload memory with a registered read at the winning slot.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_idx] <= wr_data_i;
    end
    if (look_en_i) begin
      rd_q <= mem_q[hit_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (look_en_i) begin
      hit_q <= |match;
    end
  end

  assign look_o.hit  = hit_q;
  assign look_o.data = rd_q;

endmodule

>>> sv/sav_range_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix range table
// IPv4 base and mask per slot, one masked compare per slot, and group hit
// bits registered for a final reduction in the next stage.
// ----------------------------------------------------------------------------
module sav_range_table #(
  parameter int unsigned RANGES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [7:0]  wr_slot_i,
  input  logic        wr_valid_i,
  input  logic [31:0] wr_base_i,
  input  logic [5:0]  wr_length_i,
  input  logic        look_en_i,
  input  logic [31:0] look_ip_i,
  output logic        hit_o
);
  import sav_pkg::*;

  localparam int unsigned IDX_W = (RANGES > 1) ? $clog2(RANGES) : 1;
  localparam int unsigned GRP   = 16;
  localparam int unsigned NGRP  = (RANGES + GRP - 1) / GRP;

  logic             valid_q [RANGES];
  logic [31:0]      base_q  [RANGES];
  logic [31:0]      mask_q  [RANGES];
  logic [RANGES-1:0] match;
  logic [NGRP-1:0]  grp_hit;
  logic [NGRP-1:0]  grp_hit_q;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_ok;

  // Prefix mask; lengths above 32 act as 32.
  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [6:0]  l;
    logic [31:0] m;
    l = (len > 6'd32) ? 7'd32 : {1'b0, len};
    for (int i = 0; i < 32; i++) m[i] = ((7'(i) + l) >= 7'd32);
    return m;
  endfunction

  assign wr_idx = IDX_W'(wr_slot_i);
  assign wr_ok  = wr_en_i && (32'(wr_slot_i) < RANGES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RANGES; i++) valid_q[i] <= 1'b0;
    end else if (wr_ok) begin
      valid_q[wr_idx] <= wr_valid_i;
    end
  end

  // The mask is expanded once at write time.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      base_q[wr_idx] <= wr_base_i;
      mask_q[wr_idx] <= prefix_mask(wr_length_i);
    end
  end

  // Masked compare on every slot in parallel.
  always_comb begin
    for (int i = 0; i < RANGES; i++) begin
      match[i] = valid_q[i] && (((look_ip_i ^ base_q[i]) & mask_q[i]) == 32'd0);
    end
  end

  // First level of the hit reduction.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit[g] = 1'b0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < RANGES) grp_hit[g] = grp_hit[g] | match[g * GRP + k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_hit_q <= '0;
    end else if (look_en_i) begin
      grp_hit_q <= grp_hit;
    end
  end

  assign hit_o = |grp_hit_q;

endmodule

>>> sv/sav_verdict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Verdict and statistics
// Decides pass or drop, builds the violation record, and keeps the
// wrapping statistics counters that are also read out through this stage.
// ----------------------------------------------------------------------------
module sav_verdict (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  sav_pkg::item_t      item_i,
  input  sav_pkg::bind_look_t bind_i,
  input  logic                range_hit_i,
  input  sav_pkg::mode_e      default_mode_i,
  input  logic                log_enable_i,
  output sav_pkg::result_t    result_o
);
  import sav_pkg::*;

  logic [63:0]        cnt_q [NUM_CNT];
  logic [NUM_CNT-1:0] inc;
  mode_e              mode;
  logic               v4_ok;
  logic               v6_ok;
  logic [CNT_IDX_W-1:0] cnt_sel;

  assign mode    = bind_i.hit ? bind_i.data.mode : default_mode_i;
  assign cnt_sel = item_i.slot[CNT_IDX_W-1:0];

  // Address checks for both families.
  always_comb begin
    if (mode == MODE_LOOSE) begin
      v4_ok = range_hit_i;
    end else begin
      v4_ok = bind_i.hit && bind_i.data.v4_ok && (item_i.v4_addr == bind_i.data.ipv4);
    end
    if (bind_i.hit && bind_i.data.v6_ok) begin
      v6_ok = (item_i.ipv6_high == bind_i.data.ipv6_high) &&
              (item_i.ipv6_low == bind_i.data.ipv6_low);
    end else begin
      v6_ok = (mode == MODE_LOOSE);
    end
  end

  // Verdict, violation record and counter increments.
  always_comb begin
    result_o = '0;
    inc      = '0;
    if (item_i.func == FUNC_CHECK) begin
      if (item_i.header_presence == HDR_SHORT) begin
        inc = '0;
      end else if (mode == MODE_DISABLED) begin
        inc[CNT_ALLOWED] = 1'b1;
      end else if (item_i.ethertype == ETH_IPV4) begin
        if (item_i.header_presence != HDR_ETH) begin
          if (v4_ok) begin
            inc[CNT_ALLOWED] = 1'b1;
          end else begin
            if (log_enable_i) begin
              result_o.log_valid        = 1'b1;
              result_o.log_mac          = item_i.src_mac;
              result_o.log_spoofed_ipv4 = item_i.v4_addr;
              result_o.log_allowed_ipv4 = bind_i.hit ? bind_i.data.ipv4 : 32'd0;
              inc[CNT_LOGGED]           = 1'b1;
            end
            if (mode == MODE_LOG_ONLY) begin
              inc[CNT_ALLOWED] = 1'b1;
            end else begin
              result_o.verdict = 1'b1;
              inc[CNT_DROPPED] = 1'b1;
              inc[CNT_V4_VIOL] = 1'b1;
            end
          end
        end
      end else if (item_i.ethertype == ETH_IPV6) begin
        if (item_i.header_presence != HDR_ETH) begin
          if (!v6_ok && (mode != MODE_LOG_ONLY)) begin
            if (log_enable_i) begin
              result_o.log_valid   = 1'b1;
              result_o.log_is_ipv6 = 1'b1;
              result_o.log_mac     = item_i.src_mac;
              inc[CNT_LOGGED]      = 1'b1;
            end
            result_o.verdict = 1'b1;
            inc[CNT_DROPPED] = 1'b1;
            inc[CNT_V6_VIOL] = 1'b1;
          end else begin
            inc[CNT_ALLOWED] = 1'b1;
          end
        end
      end else begin
        inc[CNT_ALLOWED] = 1'b1;
      end
    end else if (item_i.func == FUNC_RD_CNT) begin
      if (item_i.slot < 8'(NUM_CNT)) begin
        result_o.counter_value = cnt_q[cnt_sel];
      end
    end
  end

  // Counters move only when the item leaves this stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CNT; k++) cnt_q[k] <= 64'd0;
    end else if (adv_i) begin
      for (int k = 0; k < NUM_CNT; k++) begin
        if (inc[k]) cnt_q[k] <= cnt_q[k] + 64'd1;
      end
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source address validation testbench
// Sends packet checks, binding and range writes and counter reads through
// the input stream under random idling on both sides. A local model of the
// binding table, the prefix table and the statistics predicts every verdict,
// log record and counter value, and the testbench compares each result in
// order. The run steps through every mode and log setting between phases.
// ----------------------------------------------------------------------------
module tb;
  import sav_pkg::*;

  localparam int unsigned BINDINGS    = 64;
  localparam int unsigned RANGES      = 256;
  localparam int unsigned IDLE_PCT    = 26;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam logic [1:0]  HDR_FULL    = 2'd2;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [247:0]         s_axis_tdata  = '0;
  logic [1:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [183:0]         m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  source_address_validation #(
    .BINDINGS(BINDINGS),
    .RANGES  (RANGES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Local copy of the block state and configuration.
  mode_e       dflt_mode;
  logic        log_en;
  logic        bind_on    [BINDINGS];
  logic [47:0] bind_mac   [BINDINGS];
  logic [31:0] bind_v4    [BINDINGS];
  logic [63:0] bind_v6_hi [BINDINGS];
  logic [63:0] bind_v6_lo [BINDINGS];
  logic [1:0]  bind_fam   [BINDINGS];
  mode_e       bind_md    [BINDINGS];
  logic        range_on   [RANGES];
  logic [31:0] range_base [RANGES];
  logic [5:0]  range_len  [RANGES];
  logic [63:0] outcome_count [NUM_CNT];

  // Address pools, so that random checks hit bindings and ranges.
  logic [47:0] mac_pool [8];
  logic [31:0] v4_pool  [8];
  logic [63:0] v6h_pool [4];
  logic [63:0] v6l_pool [4];

  item_t       pending_items[$];
  result_t     expected_verdicts[$];
  item_t       held_item;
  result_t     rcv;
  logic        steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  // Predicts the result of one accepted transaction and updates the state.
  function automatic result_t validate_item(input item_t it);
    result_t     res;
    logic        found;
    int unsigned bi;
    mode_e       md;
    logic        ok;
    logic [5:0]  len;
    logic [31:0] mask;
    res   = '0;
    found = 1'b0;
    bi    = 0;
    ok    = 1'b0;
    case (it.func)
      FUNC_CHECK: begin
        if (it.header_presence != HDR_SHORT) begin
          // The lowest valid slot with a matching MAC wins.
          for (int i = BINDINGS - 1; i >= 0; i--) begin
            if (bind_on[i] && bind_mac[i] == it.src_mac) begin
              found = 1'b1;
              bi    = i;
            end
          end
          md = found ? bind_md[bi] : dflt_mode;
          if (md == MODE_DISABLED) begin
            outcome_count[CNT_ALLOWED] += 1;
          end else if (it.ethertype == ETH_IPV4) begin
            if (it.header_presence != HDR_ETH) begin
              if (md == MODE_LOOSE) begin
                // Loose mode looks only at the prefix table.
                for (int i = 0; i < RANGES; i++) begin
                  len  = (range_len[i] > 6'd32) ? 6'd32 : range_len[i];
                  mask = (len == 6'd0) ? 32'h0 : (~32'h0 << (32 - len));
                  if (range_on[i] && ((it.v4_addr ^ range_base[i]) & mask) == 32'h0) begin
                    ok = 1'b1;
                  end
                end
              end else begin
                ok = found && bind_fam[bi][0] && it.v4_addr == bind_v4[bi];
              end
              if (ok) begin
                outcome_count[CNT_ALLOWED] += 1;
              end else begin
                if (log_en) begin
                  res.log_valid        = 1'b1;
                  res.log_mac          = it.src_mac;
                  res.log_spoofed_ipv4 = it.v4_addr;
                  res.log_allowed_ipv4 = found ? bind_v4[bi] : 32'h0;
                  outcome_count[CNT_LOGGED] += 1;
                end
                if (md == MODE_LOG_ONLY) begin
                  outcome_count[CNT_ALLOWED] += 1;
                end else begin
                  res.verdict = 1'b1;
                  outcome_count[CNT_DROPPED] += 1;
                  outcome_count[CNT_V4_VIOL] += 1;
                end
              end
            end
          end else if (it.ethertype == ETH_IPV6) begin
            if (it.header_presence != HDR_ETH) begin
              if (found && bind_fam[bi][1]) begin
                ok = it.ipv6_high == bind_v6_hi[bi] && it.ipv6_low == bind_v6_lo[bi];
              end else begin
                ok = (md == MODE_LOOSE);
              end
              // Log-only mode lets an IPv6 mismatch through without a record.
              if (!ok && md != MODE_LOG_ONLY) begin
                if (log_en) begin
                  res.log_valid   = 1'b1;
                  res.log_is_ipv6 = 1'b1;
                  res.log_mac     = it.src_mac;
                  outcome_count[CNT_LOGGED] += 1;
                end
                res.verdict = 1'b1;
                outcome_count[CNT_DROPPED] += 1;
                outcome_count[CNT_V6_VIOL] += 1;
              end else begin
                outcome_count[CNT_ALLOWED] += 1;
              end
            end
          end else begin
            outcome_count[CNT_ALLOWED] += 1;
          end
        end
      end
      FUNC_WR_BIND: begin
        if (it.slot < BINDINGS) begin
          bind_on[it.slot]    = it.entry_flags[FLAG_VALID];
          bind_mac[it.slot]   = it.src_mac;
          bind_v4[it.slot]    = it.v4_addr;
          bind_v6_hi[it.slot] = it.ipv6_high;
          bind_v6_lo[it.slot] = it.ipv6_low;
          bind_fam[it.slot]   = {it.entry_flags[FLAG_V6], it.entry_flags[FLAG_V4]};
          bind_md[it.slot]    = mode_e'(it.entry_mode);
        end
      end
      FUNC_WR_RANGE: begin
        if (it.slot < RANGES) begin
          range_on[it.slot]   = it.entry_flags[FLAG_VALID];
          range_base[it.slot] = it.v4_addr;
          range_len[it.slot]  = it.prefix_length;
        end
      end
      FUNC_RD_CNT: begin
        if (it.slot < NUM_CNT) begin
          res.counter_value = outcome_count[it.slot];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Fills every field with random bits; the builders below override some.
  function automatic item_t noise_item();
    logic [255:0] bits;
    for (int i = 0; i < 8; i++) begin
      bits[i*32 +: 32] = $urandom();
    end
    return bits[246:0];
  endfunction

  function automatic item_t bind_item(input logic [7:0] slot, input logic [47:0] mac,
                                      input logic [2:0] flags, input mode_e md,
                                      input logic [31:0] v4, input logic [63:0] v6h,
                                      input logic [63:0] v6l);
    item_t it;
    it             = noise_item();
    it.func        = FUNC_WR_BIND;
    it.slot        = slot;
    it.src_mac     = mac;
    it.entry_flags = flags;
    it.entry_mode  = md;
    it.v4_addr     = v4;
    it.ipv6_high   = v6h;
    it.ipv6_low    = v6l;
    return it;
  endfunction

  function automatic item_t range_item(input logic [7:0] slot, input logic [31:0] base,
                                       input logic [5:0] len, input logic [2:0] flags);
    item_t it;
    it               = noise_item();
    it.func          = FUNC_WR_RANGE;
    it.slot          = slot;
    it.v4_addr       = base;
    it.prefix_length = len;
    it.entry_flags   = flags;
    return it;
  endfunction

  function automatic item_t check_item(input logic [47:0] mac, input logic [15:0] eth,
                                       input logic [1:0] hp, input logic [31:0] v4,
                                       input logic [63:0] v6h, input logic [63:0] v6l);
    item_t it;
    it                 = noise_item();
    it.func            = FUNC_CHECK;
    it.src_mac         = mac;
    it.ethertype       = eth;
    it.header_presence = hp;
    it.v4_addr         = v4;
    it.ipv6_high       = v6h;
    it.ipv6_low        = v6l;
    return it;
  endfunction

  function automatic item_t count_item(input logic [7:0] slot);
    item_t it;
    it      = noise_item();
    it.func = FUNC_RD_CNT;
    it.slot = slot;
    return it;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("verdict=%0d log=%0d v6=%0d mac=%h spoof=%h allow=%h cnt=%h",
                     r.verdict, r.log_valid, r.log_is_ipv6, r.log_mac,
                     r.log_spoofed_ipv4, r.log_allowed_ipv4, r.counter_value);
  endfunction

  task automatic report_mismatch(input result_t want, input result_t got, input logic orphan);
    mismatches++;
    if (mismatches <= 10) begin
      $display("result mismatch at %0t: expected %s, actual %s", $time,
               orphan ? "none" : fmt_result(want), fmt_result(got));
    end
  endtask

  // Returns once nothing is queued, in flight or awaited.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Writes one register through the configuration channel.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_DEFAULT_MODE) begin
      dflt_mode = mode_e'(val[1:0]);
    end else if (idx == CFG_LOG_ENABLE) begin
      log_en = val[0];
    end
  endtask

  // Drains the block, then sets both registers; unused data bits are random.
  task automatic configure(input mode_e md, input logic le);
    wait_drained();
    write_reg(CFG_DEFAULT_MODE, {6'($urandom()), md});
    write_reg(CFG_LOG_ENABLE, {7'($urandom()), le});
    @(negedge clk_i);
  endtask

  // One random phase: mostly packet checks on pooled addresses.
  task automatic run_phase(input mode_e md, input logic le, input int unsigned n,
                           input logic calm);
    item_t       it;
    int unsigned sel;
    int unsigned mi;
    int unsigned vi;
    int unsigned hi;
    logic [47:0] mac;
    logic [15:0] eth;
    logic [1:0]  hp;
    logic [31:0] v4;
    logic [63:0] v6h;
    logic [63:0] v6l;
    configure(md, le);
    steady = calm;
    repeat (n) begin
      sel = $urandom_range(99);
      mi  = $urandom_range(7);
      vi  = $urandom_range(7);
      hi  = $urandom_range(3);
      if (sel < 12) begin
        it = bind_item(($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(15)),
                       mac_pool[mi],
                       ($urandom_range(3) == 0) ? 3'($urandom()) : {2'($urandom()), 1'b1},
                       mode_e'($urandom_range(3)), v4_pool[vi], v6h_pool[hi], v6l_pool[hi]);
      end else if (sel < 20) begin
        it = range_item(($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(31)),
                        v4_pool[vi] ^ 32'($urandom_range(255)),
                        ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(16, 32)),
                        ($urandom_range(4) == 0) ? 3'($urandom()) : {2'($urandom()), 1'b1});
      end else if (sel < 27) begin
        it = count_item(($urandom_range(4) == 0) ? 8'($urandom()) : 8'($urandom_range(7)));
      end else begin
        mac = ($urandom_range(9) == 0) ? 48'({$urandom(), $urandom()}) : mac_pool[mi];
        sel = $urandom_range(99);
        eth = (sel < 45) ? ETH_IPV4 : (sel < 85) ? ETH_IPV6 : 16'($urandom());
        hp  = ($urandom_range(4) == 0) ? 2'($urandom()) : HDR_FULL;
        sel = $urandom_range(99);
        v4  = (sel < 60) ? v4_pool[vi] :
              (sel < 75) ? (v4_pool[vi] ^ 32'($urandom_range(255))) : $urandom();
        sel = $urandom_range(99);
        v6h = (sel < 75) ? v6h_pool[hi] : {$urandom(), $urandom()};
        v6l = (sel < 60) ? v6l_pool[hi] : {$urandom(), $urandom()};
        it  = check_item(mac, eth, hp, v4, v6h, v6l);
      end
      pending_items.push_back(it);
    end
    wait_drained();
    steady = 1'b0;
  endtask

  // Input driver: predicts on acceptance, then presents the next item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_verdicts.push_back(validate_item(held_item));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          held_item     = pending_items.pop_front();
          s_axis_tdata  <= {3'b000, held_item.prefix_length, held_item.entry_mode,
                            held_item.entry_flags, held_item.ipv6_low, held_item.ipv6_high,
                            held_item.v4_addr, held_item.header_presence,
                            held_item.ethertype, held_item.src_mac, held_item.slot};
          s_axis_tuser  <= held_item.func;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transaction with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        rcv.verdict          = m_axis_tdata[0];
        rcv.log_is_ipv6      = m_axis_tdata[1];
        rcv.log_mac          = m_axis_tdata[49:2];
        rcv.log_spoofed_ipv4 = m_axis_tdata[81:50];
        rcv.log_allowed_ipv4 = m_axis_tdata[113:82];
        rcv.counter_value    = m_axis_tdata[177:114];
        rcv.log_valid        = m_axis_tuser[0];
        if (expected_verdicts.size() == 0) begin
          report_mismatch('0, rcv, 1'b1);
        end else if (rcv !== expected_verdicts[0]) begin
          report_mismatch(expected_verdicts.pop_front(), rcv, 1'b0);
        end else begin
          void'(expected_verdicts.pop_front());
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: ends the run after a long stretch without any transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    dflt_mode = MODE_DISABLED;
    log_en    = 1'b0;
    for (int i = 0; i < BINDINGS; i++) begin
      bind_on[i]    = 1'b0;
      bind_mac[i]   = '0;
      bind_v4[i]    = '0;
      bind_v6_hi[i] = '0;
      bind_v6_lo[i] = '0;
      bind_fam[i]   = '0;
      bind_md[i]    = MODE_DISABLED;
    end
    for (int i = 0; i < RANGES; i++) begin
      range_on[i]   = 1'b0;
      range_base[i] = '0;
      range_len[i]  = '0;
    end
    for (int i = 0; i < NUM_CNT; i++) begin
      outcome_count[i] = '0;
    end
    mac_pool[0] = 48'h0200_0000_000A;
    mac_pool[1] = 48'hFFFF_FFFF_FFFF;
    mac_pool[2] = 48'h0000_0000_0000;
    mac_pool[3] = 48'h8E2C_4400_1F03;
    v4_pool[0]  = 32'hC0A8_010A;
    v4_pool[1]  = 32'hC0A8_0114;
    v4_pool[2]  = 32'hAC10_0005;
    v4_pool[3]  = 32'h0A01_0203;
    v4_pool[4]  = 32'h0000_0000;
    v4_pool[5]  = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) begin
      mac_pool[i] = {$urandom(), $urandom()};
    end
    v4_pool[6] = $urandom();
    v4_pool[7] = $urandom();
    for (int i = 0; i < 4; i++) begin
      v6h_pool[i] = {$urandom(), $urandom()};
      v6l_pool[i] = {$urandom(), $urandom()};
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks of the corner cases, strict default with logging.
    configure(MODE_STRICT, 1'b1);
    pending_items.push_back(count_item(8'(CNT_ALLOWED)));
    // A short Ethernet header passes without touching a counter.
    pending_items.push_back(check_item(mac_pool[0], ETH_IPV4, HDR_SHORT, v4_pool[1], 0, 0));
    // Two bindings for one MAC: the lower slot decides.
    pending_items.push_back(bind_item(8'd3, mac_pool[0], 3'b111, MODE_STRICT, v4_pool[0],
                                      v6h_pool[0], v6l_pool[0]));
    pending_items.push_back(bind_item(8'd1, mac_pool[0], 3'b011, MODE_LOOSE, v4_pool[1],
                                      v6h_pool[0], v6l_pool[0]));
    pending_items.push_back(range_item(8'd0, 32'h0A00_0000, 6'd8, 3'b001));
    // A prefix length above 32 acts as an exact match.
    pending_items.push_back(range_item(8'd255, v4_pool[2], 6'd40, 3'b111));
    // Loose mode ignores the bound IPv4 address.
    pending_items.push_back(check_item(mac_pool[0], ETH_IPV4, HDR_FULL, v4_pool[3], 0, 0));
    pending_items.push_back(check_item(mac_pool[0], ETH_IPV4, HDR_FULL, v4_pool[1], 0, 0));
    pending_items.push_back(check_item(mac_pool[0], ETH_IPV4, HDR_FULL, v4_pool[2], 0, 0));
    // Loose mode without an IPv6 binding passes IPv6.
    pending_items.push_back(check_item(mac_pool[0], ETH_IPV6, HDR_FULL, 0, '1, '1));
    // A short IP header passes; header code three counts as full.
    pending_items.push_back(check_item(mac_pool[0], ETH_IPV4, HDR_ETH, v4_pool[1], 0, 0));
    pending_items.push_back(check_item(mac_pool[0], ETH_IPV4, 2'd3, 32'h0AFF_FFFF, 0, 0));
    // A binding slot beyond the table is ignored, so the MAC stays unknown.
    pending_items.push_back(bind_item(8'd64, mac_pool[1], 3'b111, MODE_DISABLED, v4_pool[0],
                                      v6h_pool[1], v6l_pool[1]));
    pending_items.push_back(check_item(mac_pool[1], ETH_IPV4, HDR_FULL, 32'hFFFF_FFFF, 0, 0));
    // Log-only: IPv4 mismatch logs and passes, IPv6 mismatch passes silently.
    pending_items.push_back(bind_item(8'd2, mac_pool[1], 3'b111, MODE_LOG_ONLY, v4_pool[0],
                                      v6h_pool[1], v6l_pool[1]));
    pending_items.push_back(check_item(mac_pool[1], ETH_IPV4, HDR_FULL, v4_pool[4], 0, 0));
    pending_items.push_back(check_item(mac_pool[1], ETH_IPV6, HDR_FULL, 0, v6h_pool[1], 0));
    pending_items.push_back(check_item(mac_pool[1], ETH_IPV6, HDR_FULL, 0, v6h_pool[1],
                                       v6l_pool[1]));
    // Strict with only an IPv6 binding: both families can fail; non-IP passes.
    pending_items.push_back(bind_item(8'd5, mac_pool[2], 3'b101, MODE_STRICT, v4_pool[4],
                                      v6h_pool[2], v6l_pool[2]));
    pending_items.push_back(check_item(mac_pool[2], ETH_IPV6, HDR_FULL, 0, v6h_pool[2], 0));
    pending_items.push_back(check_item(mac_pool[2], ETH_IPV4, HDR_FULL, v4_pool[4], 0, 0));
    pending_items.push_back(check_item(mac_pool[2], 16'h1234, HDR_FULL, 0, 0, 0));
    // Disabled mode counts a short IP header as allowed.
    pending_items.push_back(bind_item(8'd6, mac_pool[3], 3'b001, MODE_DISABLED, 0, 0, 0));
    pending_items.push_back(check_item(mac_pool[3], ETH_IPV4, HDR_ETH, 0, 0, 0));
    for (int i = 0; i <= NUM_CNT; i++) begin
      pending_items.push_back(count_item(8'(i)));
    end
    pending_items.push_back(count_item(8'hFF));

    // Random phases across every mode and log setting.
    run_phase(MODE_DISABLED, 1'b0, 170, 1'b0);
    run_phase(MODE_LOOSE,    1'b1, 170, 1'b0);
    run_phase(MODE_LOG_ONLY, 1'b1, 170, 1'b0);
    run_phase(MODE_STRICT,   1'b0, 170, 1'b1);
    run_phase(MODE_LOOSE,    1'b0, 170, 1'b0);
    run_phase(MODE_LOG_ONLY, 1'b0, 170, 1'b0);
    run_phase(MODE_STRICT,   1'b1, 170, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
